// ===== src/hgcm_pkg.sv =====
// Shared types, constants and register codes of the height gradient color map.
`timescale 1ns / 1ps

package hgcm_pkg;

    localparam int NUM_STOP_REGS   = 7;
    localparam int MAX_STOPS_DEF   = 7;
    localparam int HEIGHT_BITS_DEF = 16;
    localparam int THR_BITS        = 16;
    localparam int CHAN_BITS       = 8;
    localparam int NUM_CHAN        = 3;
    localparam int PROD_BITS       = 24;
    localparam int NUM_BITS        = 25;
    localparam int QUO_BITS        = 8;
    localparam int CNT_BITS        = 3;
    localparam int IDX_BITS        = 3;
    localparam int ADDR_BITS       = 6;
    localparam int DATA_BITS       = 64;
    localparam int STOP_BITS       = 40;

    // Channel positions inside a packed color.
    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    // Register indexes (byte address divided by eight).
    localparam logic [IDX_BITS-1:0] REG_STOP_COUNT = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_STOP_BASE  = 3'd1;

    typedef struct packed {
        logic [THR_BITS-1:0]                 thr;
        logic [NUM_CHAN-1:0][CHAN_BITS-1:0] color;
    } t_stop;

    typedef t_stop [NUM_STOP_REGS-1:0] t_stop_arr;

    localparam logic [CNT_BITS-1:0] STOP_COUNT_RST = 3'd7;
    localparam t_stop_arr STOP_RST = {
        40'd1518370944, 40'd1342210048, 40'd1174470400, 40'd1022731105,
        40'd671088895,  40'd335544448,  40'd167772160
    };

    // Segment chosen for one sample: width, offset and the two end colors.
    typedef struct packed {
        logic [THR_BITS-1:0]                 w;
        logic [THR_BITS-1:0]                 d;
        logic [NUM_CHAN-1:0][CHAN_BITS-1:0] a;
        logic [NUM_CHAN-1:0][CHAN_BITS-1:0] b;
    } t_sel;

    // State of the long division, one remainder and quotient per channel.
    typedef struct packed {
        logic [NUM_CHAN-1:0][NUM_BITS-1:0]  rem;
        logic [THR_BITS-1:0]                 w;
        logic [NUM_CHAN-1:0][QUO_BITS-1:0]  quo;
    } t_div;

endpackage

// ===== src/hgcm_segment.sv =====
// Two-stage segment search: threshold compares, then segment selection.
`timescale 1ns / 1ps

module hgcm_segment #(
    parameter int MAX_STOPS   = hgcm_pkg::MAX_STOPS_DEF,
    parameter int HEIGHT_BITS = hgcm_pkg::HEIGHT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [hgcm_pkg::THR_BITS-1:0]     i_height,
    input  hgcm_pkg::t_stop_arr               i_stops,
    input  logic [hgcm_pkg::CNT_BITS-1:0]     i_stop_count,
    input  logic                              i_ready,
    output logic                              o_ready,
    output logic                              o_valid,
    output hgcm_pkg::t_sel                    o_sel
);

    localparam int NUM_SEG = MAX_STOPS - 1;
    localparam logic [hgcm_pkg::CNT_BITS-1:0] MAX_N = hgcm_pkg::CNT_BITS'(MAX_STOPS);
    localparam logic [hgcm_pkg::THR_BITS-1:0] H_MASK =
        hgcm_pkg::THR_BITS'((32'd1 << HEIGHT_BITS) - 32'd1);

    // Stage A registers.
    logic                              r_a_valid;
    logic [hgcm_pkg::THR_BITS-1:0]     r_a_h;
    logic [NUM_SEG-1:0]                r_a_match;
    logic                              r_a_below;
    logic [hgcm_pkg::IDX_BITS-1:0]     r_a_last;
    logic [hgcm_pkg::THR_BITS-1:0]     n_a_h;
    logic [NUM_SEG-1:0]                n_a_match;
    logic [hgcm_pkg::CNT_BITS-1:0]     n_cnt;

    // Stage B registers.
    logic                              r_b_valid;
    hgcm_pkg::t_sel                    r_b_sel;
    hgcm_pkg::t_sel                    n_b_sel;

    logic                              a_ready;
    logic                              b_ready;
    logic                              found;
    logic [hgcm_pkg::IDX_BITS-1:0]     sel;
    logic [hgcm_pkg::IDX_BITS-1:0]     sel_hi;
    logic [hgcm_pkg::IDX_BITS-1:0]     fb;
    logic [hgcm_pkg::THR_BITS-1:0]     lo;
    logic [hgcm_pkg::THR_BITS-1:0]     hi;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;
    assign o_valid = r_b_valid;
    assign o_sel   = r_b_sel;

    always_comb begin
        n_a_h = i_height & H_MASK;
        n_cnt = i_stop_count;
        if (n_cnt < 3'd2) begin
            n_cnt = 3'd2;
        end
        if (n_cnt > MAX_N) begin
            n_cnt = MAX_N;
        end
        for (int i = 0; i < NUM_SEG; i++) begin
            n_a_match[i] = ((hgcm_pkg::CNT_BITS'(i) + 3'd1) < n_cnt)
                && (n_a_h >= i_stops[i].thr) && (n_a_h <= i_stops[i + 1].thr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
        if (a_ready) begin
            r_a_h     <= n_a_h;
            r_a_match <= n_a_match;
            r_a_below <= n_a_h <= i_stops[0].thr;
            r_a_last  <= n_cnt - 3'd1;
        end
    end

    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int i = NUM_SEG - 1; i >= 0; i--) begin
            if (r_a_match[i]) begin
                found = 1'b1;
                sel   = hgcm_pkg::IDX_BITS'(i);
            end
        end
        sel_hi    = sel + 3'd1;
        fb        = r_a_below ? '0 : r_a_last;
        lo        = i_stops[sel].thr;
        hi        = i_stops[sel_hi].thr;
        n_b_sel.w = hi - lo;
        n_b_sel.d = r_a_h - lo;
        n_b_sel.a = i_stops[sel].color;
        n_b_sel.b = i_stops[sel_hi].color;
        // A flat segment or a sample outside the ramp divides end color a by one.
        if (!found || (hi == lo)) begin
            n_b_sel.w = 16'd1;
            n_b_sel.d = '0;
            n_b_sel.b = '0;
            n_b_sel.a = found ? i_stops[sel].color : i_stops[fb].color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
        if (b_ready) begin
            r_b_sel <= n_b_sel;
        end
    end

endmodule

// ===== src/hgcm_interp.sv =====
// Two-stage weighting: products of both end colors, then the rounded numerator.
`timescale 1ns / 1ps

module hgcm_interp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  hgcm_pkg::t_sel  i_sel,
    input  logic            i_ready,
    output logic            o_ready,
    output logic            o_valid,
    output hgcm_pkg::t_div  o_div
);

    logic                                                    r_c_valid;
    logic [hgcm_pkg::NUM_CHAN-1:0][hgcm_pkg::PROD_BITS-1:0]  r_c_pa;
    logic [hgcm_pkg::NUM_CHAN-1:0][hgcm_pkg::PROD_BITS-1:0]  r_c_pb;
    logic [hgcm_pkg::THR_BITS-1:0]                           r_c_w;
    logic [hgcm_pkg::NUM_CHAN-1:0][hgcm_pkg::PROD_BITS-1:0]  n_c_pa;
    logic [hgcm_pkg::NUM_CHAN-1:0][hgcm_pkg::PROD_BITS-1:0]  n_c_pb;
    logic [hgcm_pkg::THR_BITS-1:0]                           diff;

    logic                                                    r_d_valid;
    hgcm_pkg::t_div                                          r_d_div;
    hgcm_pkg::t_div                                          n_d_div;

    logic                                                    c_ready;
    logic                                                    d_ready;

    assign d_ready = !r_d_valid || i_ready;
    assign c_ready = !r_c_valid || d_ready;
    assign o_ready = c_ready;
    assign o_valid = r_d_valid;
    assign o_div   = r_d_div;

    always_comb begin
        diff = i_sel.w - i_sel.d;
        for (int ch = 0; ch < hgcm_pkg::NUM_CHAN; ch++) begin
            n_c_pa[ch] = {16'd0, i_sel.a[ch]} * {8'd0, diff};
            n_c_pb[ch] = {16'd0, i_sel.b[ch]} * {8'd0, i_sel.d};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_ready) begin
            r_c_valid <= i_valid;
        end
        if (c_ready) begin
            r_c_pa <= n_c_pa;
            r_c_pb <= n_c_pb;
            r_c_w  <= i_sel.w;
        end
    end

    // Half the width is added so that the truncating division rounds halves up.
    always_comb begin
        n_d_div.w   = r_c_w;
        n_d_div.quo = '0;
        for (int ch = 0; ch < hgcm_pkg::NUM_CHAN; ch++) begin
            n_d_div.rem[ch] = {1'b0, r_c_pa[ch]} + {1'b0, r_c_pb[ch]}
                + {10'd0, r_c_w[hgcm_pkg::THR_BITS-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (d_ready) begin
            r_d_valid <= r_c_valid;
        end
        if (d_ready) begin
            r_d_div <= n_d_div;
        end
    end

endmodule

// ===== src/hgcm_div_stage.sv =====
// One restoring division step that settles one quotient bit of every channel.
`timescale 1ns / 1ps

module hgcm_div_stage #(
    parameter int BIT = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  hgcm_pkg::t_div  i_div,
    input  logic            i_ready,
    output logic            o_ready,
    output logic            o_valid,
    output hgcm_pkg::t_div  o_div
);

    logic                              r_valid;
    hgcm_pkg::t_div                    r_div;
    hgcm_pkg::t_div                    n_div;
    logic [hgcm_pkg::NUM_BITS-1:0]     dvs;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign dvs     = {9'd0, i_div.w} << BIT;

    always_comb begin
        n_div = i_div;
        for (int ch = 0; ch < hgcm_pkg::NUM_CHAN; ch++) begin
            if (i_div.rem[ch] >= dvs) begin
                n_div.rem[ch]      = i_div.rem[ch] - dvs;
                n_div.quo[ch][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready) begin
            r_div <= n_div;
        end
    end

endmodule

// ===== src/height_gradient_color_map.sv =====
// Top level of the height gradient color map: registers, pipeline and checks.
`timescale 1ns / 1ps

// Maps one unsigned height sample per transaction to an RGB888 color through a
// piecewise linear ramp of up to seven stops held in registers.
// Input channel: i_valid, o_stall and i_height. A transaction completes on a
// rising edge with i_valid high and o_stall low. Output channel: o_valid,
// i_stall and o_red, o_green, o_blue, with the same rule.
// Registers sit on an APB-style port, one per 8-byte slot: stop_count at 0,
// then stop 0 to stop 6 (threshold in bits 39:24, color in 23:0). Write them
// only while no transaction is in flight.
// The pipeline is twelve register stages deep: two for the segment search,
// two for the products and rounded numerator, and eight for a long division
// that settles one quotient bit per stage. One sample is accepted every cycle
// while o_stall is low.
// Each stage holds its data when the next one is full and stalled, so empty
// stages still fill while i_stall is high; o_stall rises only once every stage
// is occupied. Nothing is dropped or duplicated under stall.
// Reset (synchronous, active low) empties the pipeline and restores the
// default ramp of seven stops.

module height_gradient_color_map #(
    parameter int MAX_STOPS   = hgcm_pkg::MAX_STOPS_DEF,
    parameter int HEIGHT_BITS = hgcm_pkg::HEIGHT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [hgcm_pkg::THR_BITS-1:0]      i_height,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [hgcm_pkg::CHAN_BITS-1:0]     o_red,
    output logic [hgcm_pkg::CHAN_BITS-1:0]     o_green,
    output logic [hgcm_pkg::CHAN_BITS-1:0]     o_blue,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hgcm_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [hgcm_pkg::DATA_BITS-1:0]     pwdata,
    output logic [hgcm_pkg::DATA_BITS-1:0]     prdata,
    output logic                               pready
);

    localparam int DIV_STAGES = hgcm_pkg::QUO_BITS;

    // Configuration registers.
    logic [hgcm_pkg::CNT_BITS-1:0]  r_stop_count;
    hgcm_pkg::t_stop_arr            r_stops;
    logic [hgcm_pkg::IDX_BITS-1:0]  reg_idx;
    logic [hgcm_pkg::IDX_BITS-1:0]  stop_idx;
    logic                           cfg_wr;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[hgcm_pkg::ADDR_BITS-1:3];
    assign stop_idx = reg_idx - hgcm_pkg::REG_STOP_BASE;
    assign cfg_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= hgcm_pkg::STOP_COUNT_RST;
            r_stops      <= hgcm_pkg::STOP_RST;
        end else if (cfg_wr) begin
            if (reg_idx == hgcm_pkg::REG_STOP_COUNT) begin
                r_stop_count <= pwdata[hgcm_pkg::CNT_BITS-1:0];
            end else begin
                r_stops[stop_idx] <= pwdata[hgcm_pkg::STOP_BITS-1:0];
            end
        end
    end

    always_comb begin
        if (reg_idx == hgcm_pkg::REG_STOP_COUNT) begin
            prdata = {61'd0, r_stop_count};
        end else begin
            prdata = {24'd0, r_stops[stop_idx]};
        end
    end

    // Segment search and interpolation front end.
    logic            seg_ready;
    logic            seg_valid;
    hgcm_pkg::t_sel  seg_sel;
    logic            int_ready;

    hgcm_segment #(
        .MAX_STOPS   (MAX_STOPS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_segment (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_height     (i_height),
        .i_stops      (r_stops),
        .i_stop_count (r_stop_count),
        .i_ready      (int_ready),
        .o_ready      (seg_ready),
        .o_valid      (seg_valid),
        .o_sel        (seg_sel)
    );

    // Division chain: entry 0 is the numerator stage, the last entry the result.
    logic [DIV_STAGES:0]  div_valid;
    logic [DIV_STAGES:0]  div_ready;
    hgcm_pkg::t_div       div_data [DIV_STAGES+1];

    hgcm_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (seg_valid),
        .i_sel   (seg_sel),
        .i_ready (div_ready[0]),
        .o_ready (int_ready),
        .o_valid (div_valid[0]),
        .o_div   (div_data[0])
    );

    for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
        hgcm_div_stage #(
            .BIT (DIV_STAGES - g)
        ) u_div_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_valid[g-1]),
            .i_div   (div_data[g-1]),
            .i_ready (div_ready[g]),
            .o_ready (div_ready[g-1]),
            .o_valid (div_valid[g]),
            .o_div   (div_data[g])
        );
    end

    assign div_ready[DIV_STAGES] = !i_stall;
    assign o_stall = !seg_ready;
    assign o_valid = div_valid[DIV_STAGES];
    assign o_red   = div_data[DIV_STAGES].quo[hgcm_pkg::CH_RED];
    assign o_green = div_data[DIV_STAGES].quo[hgcm_pkg::CH_GREEN];
    assign o_blue  = div_data[DIV_STAGES].quo[hgcm_pkg::CH_BLUE];

`ifndef SYNTH
    // The divisor is never zero and every quotient fits in eight bits.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_valid[0] |-> (div_data[0].w != '0)
            && (div_data[0].rem[0] < ({9'd0, div_data[0].w} << DIV_STAGES))
            && (div_data[0].rem[1] < ({9'd0, div_data[0].w} << DIV_STAGES))
            && (div_data[0].rem[2] < ({9'd0, div_data[0].w} << DIV_STAGES)))
        else $error("numerator out of range for an eight-bit quotient");

    // After the last division step each remainder is below the divisor.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (div_data[DIV_STAGES].rem[0] < {9'd0, div_data[DIV_STAGES].w})
            && (div_data[DIV_STAGES].rem[1] < {9'd0, div_data[DIV_STAGES].w})
            && (div_data[DIV_STAGES].rem[2] < {9'd0, div_data[DIV_STAGES].w}))
        else $error("division did not converge");
`endif

endmodule
